>>> rtl/hlf_pkg.sv
`timescale 1ns / 1ps

package hlf_pkg;

  localparam int LEN_BITS_DEF = 32;
  localparam int KW_LEN       = 15;

  // phase codes
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_DROP   = 2'd2;

  // byte_part codes
  localparam logic [1:0] PART_HEADER = 2'd0;
  localparam logic [1:0] PART_BODY   = 2'd1;
  localparam logic [1:0] PART_DROP   = 2'd2;

  // value field parse state
  localparam logic [2:0] VS_IDLE     = 3'd0;
  localparam logic [2:0] VS_LEAD     = 3'd1;
  localparam logic [2:0] VS_SIGN     = 3'd2;
  localparam logic [2:0] VS_DIGITS   = 3'd3;
  localparam logic [2:0] VS_TRAIL    = 3'd4;
  localparam logic [2:0] VS_INVALID  = 3'd5;
  localparam logic [2:0] VS_VALID    = 3'd6;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_C  = 8'h63;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       connection_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  byte_part;
    logic        request_end;
    logic        length_error;
    logic [31:0] body_length;
  } out_item_t;

  // "content-length:" one character per index
  function automatic logic [7:0] kw_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h6C; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

>>> rtl/http_request_length_framer_top.sv
`timescale 1ns / 1ps
// Path: an accepted byte waits in the input register; its parse result is loaded into the
// result register once that is free, so two register stages from in_data to out_data.
// Throughput: one byte per cycle while out_ready is high; the whole per-byte parse is one
// combinational pass between the input register and the result register.
// Reset: synchronous, active low; clears handshake valids and all parser state
// (header phase, no match, length 0). in_ready is high once reset is released.
module http_request_length_framer_top #(
  parameter int LEN_BITS = hlf_pkg::LEN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hlf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hlf_pkg::out_item_t out_data
);

  logic               item_valid;
  hlf_pkg::in_item_t  item;
  hlf_pkg::out_item_t result;
  logic               load_ok;
  logic               step;

  // advance one byte when the result register can take it
  assign step = item_valid && load_ok;

  hlf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .drain      (step),
    .item_valid (item_valid),
    .item       (item)
  );

  hlf_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .result (result)
  );

  hlf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .result    (result),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/hlf_in_stage.sv
`timescale 1ns / 1ps

module hlf_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hlf_pkg::in_item_t in_data,
  input  logic              drain,
  output logic              item_valid,
  output hlf_pkg::in_item_t item
);

  logic              valid_r;
  logic              valid_nxt;
  hlf_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || drain;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

>>> rtl/hlf_core.sv
`timescale 1ns / 1ps

module hlf_core #(
  parameter int LEN_BITS = hlf_pkg::LEN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  hlf_pkg::in_item_t  item,
  output hlf_pkg::out_item_t result
);

  localparam int EXT_W = (LEN_BITS > 32) ? LEN_BITS : 32;

  logic [1:0]          phase_r,   phase_nxt;
  logic [1:0]          term_r,    term_nxt;
  logic [3:0]          kw_r,      kw_nxt;
  logic                found_r,   found_nxt;
  logic [2:0]          vs_r,      vs_nxt;
  logic                prev_cr_r, prev_cr_nxt;
  logic                neg_r,     neg_nxt;
  logic [LEN_BITS-1:0] acc_r,     acc_nxt;
  logic [LEN_BITS-1:0] rem_r,     rem_nxt;

  always_comb begin
    logic [7:0]          c;
    logic [7:0]          lower;
    logic [3:0]          dval;
    logic                digit;
    logic [LEN_BITS+3:0] tenx;
    logic                ovf;
    logic [LEN_BITS-1:0] rem_dec;
    logic [LEN_BITS-1:0] eff_acc;
    logic [EXT_W-1:0]    acc_ext;
    logic                hit;
    logic                bad;
    logic                clr;

    c       = item.data_byte;
    lower   = ((c >= hlf_pkg::CH_UP_A) && (c <= hlf_pkg::CH_UP_Z)) ?
              c + hlf_pkg::CASE_GAP : c;
    digit   = (c >= hlf_pkg::CH_ZERO) && (c <= hlf_pkg::CH_NINE);
    dval    = 4'(c - hlf_pkg::CH_ZERO);
    hit     = 1'b0;
    bad     = 1'b0;
    clr     = 1'b0;

    // a new connection clears the parser ahead of this byte
    if (item.connection_start) begin
      phase_nxt   = hlf_pkg::PH_HEADER;
      term_nxt    = '0;
      kw_nxt      = '0;
      found_nxt   = 1'b0;
      vs_nxt      = hlf_pkg::VS_IDLE;
      prev_cr_nxt = 1'b0;
      neg_nxt     = 1'b0;
      acc_nxt     = '0;
      rem_nxt     = '0;
    end else begin
      phase_nxt   = phase_r;
      term_nxt    = term_r;
      kw_nxt      = kw_r;
      found_nxt   = found_r;
      vs_nxt      = vs_r;
      prev_cr_nxt = prev_cr_r;
      neg_nxt     = neg_r;
      acc_nxt     = acc_r;
      rem_nxt     = rem_r;
    end

    tenx    = ({4'b0, acc_nxt} << 3) + ({4'b0, acc_nxt} << 1) + (LEN_BITS+4)'(dval);
    ovf     = |tenx[LEN_BITS+3:LEN_BITS];
    rem_dec = rem_nxt - LEN_BITS'(1);
    acc_ext = EXT_W'(acc_nxt);
    eff_acc = acc_nxt;

    result.byte_out     = c;
    result.byte_part    = hlf_pkg::PART_HEADER;
    result.request_end  = 1'b0;
    result.length_error = 1'b0;
    result.body_length  = '0;

    case (phase_nxt)
      hlf_pkg::PH_BODY: begin
        result.byte_part = hlf_pkg::PART_BODY;
        rem_nxt          = rem_dec;
        if (rem_dec == '0) begin
          result.request_end = 1'b1;
          result.body_length = acc_ext[31:0];
          phase_nxt          = hlf_pkg::PH_HEADER;
          clr                = 1'b1;
        end
      end
      hlf_pkg::PH_HEADER: begin
        // value field of the matched header
        if (found_nxt && (vs_nxt == hlf_pkg::VS_LEAD || vs_nxt == hlf_pkg::VS_SIGN ||
                          vs_nxt == hlf_pkg::VS_DIGITS || vs_nxt == hlf_pkg::VS_TRAIL)) begin
          if (c == hlf_pkg::CH_LF && prev_cr_nxt) begin
            vs_nxt = (vs_nxt == hlf_pkg::VS_DIGITS || vs_nxt == hlf_pkg::VS_TRAIL) ?
                     hlf_pkg::VS_VALID : hlf_pkg::VS_INVALID;
          end else begin
            case (vs_nxt)
              hlf_pkg::VS_LEAD: begin
                if (!hlf_pkg::is_blank(c)) begin
                  if (c == hlf_pkg::CH_PLUS || c == hlf_pkg::CH_MINUS) begin
                    neg_nxt = (c == hlf_pkg::CH_MINUS);
                    vs_nxt  = hlf_pkg::VS_SIGN;
                  end else if (digit) begin
                    acc_nxt = LEN_BITS'(dval);
                    vs_nxt  = hlf_pkg::VS_DIGITS;
                  end else begin
                    vs_nxt = hlf_pkg::VS_INVALID;
                  end
                end
              end
              hlf_pkg::VS_SIGN, hlf_pkg::VS_DIGITS: begin
                if (digit) begin
                  if (ovf) begin
                    vs_nxt = hlf_pkg::VS_INVALID;
                  end else begin
                    acc_nxt = tenx[LEN_BITS-1:0];
                    vs_nxt  = hlf_pkg::VS_DIGITS;
                  end
                end else if (vs_nxt == hlf_pkg::VS_DIGITS && hlf_pkg::is_blank(c)) begin
                  vs_nxt = hlf_pkg::VS_TRAIL;
                end else begin
                  vs_nxt = hlf_pkg::VS_INVALID;
                end
              end
              hlf_pkg::VS_TRAIL: begin
                if (!hlf_pkg::is_blank(c)) begin
                  vs_nxt = hlf_pkg::VS_INVALID;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // keyword search, first match only
        if (!found_nxt) begin
          if (lower == hlf_pkg::kw_char(kw_nxt)) begin
            kw_nxt = kw_nxt + 4'd1;
          end else begin
            kw_nxt = (lower == hlf_pkg::CH_LO_C) ? 4'd1 : 4'd0;
          end
          if (kw_nxt == 4'(hlf_pkg::KW_LEN)) begin
            found_nxt = 1'b1;
            vs_nxt    = hlf_pkg::VS_LEAD;
          end
        end

        // header terminator CR LF CR LF
        if (c == hlf_pkg::CH_CR) begin
          term_nxt = (term_nxt == 2'd2) ? 2'd3 : 2'd1;
        end else if (c == hlf_pkg::CH_LF && term_nxt == 2'd3) begin
          hit      = 1'b1;
          term_nxt = 2'd0;
        end else if (c == hlf_pkg::CH_LF && term_nxt == 2'd1) begin
          term_nxt = 2'd2;
        end else begin
          term_nxt = 2'd0;
        end
        prev_cr_nxt = (c == hlf_pkg::CH_CR);

        if (hit) begin
          bad = (vs_nxt == hlf_pkg::VS_LEAD) || (vs_nxt == hlf_pkg::VS_SIGN) ||
                (vs_nxt == hlf_pkg::VS_INVALID) || (neg_nxt && (acc_nxt != '0));
          eff_acc = (vs_nxt == hlf_pkg::VS_IDLE) ? '0 : acc_nxt;
          acc_ext = EXT_W'(eff_acc);
          if (bad) begin
            result.length_error = 1'b1;
            phase_nxt           = hlf_pkg::PH_DROP;
            clr                 = 1'b1;
          end else if (eff_acc == '0) begin
            result.request_end = 1'b1;
            clr                = 1'b1;
          end else begin
            result.body_length = acc_ext[31:0];
            acc_nxt            = eff_acc;
            rem_nxt            = eff_acc;
            phase_nxt          = hlf_pkg::PH_BODY;
          end
        end
      end
      default: begin
        result.byte_part = hlf_pkg::PART_DROP;
      end
    endcase

    if (clr) begin
      term_nxt    = '0;
      kw_nxt      = '0;
      found_nxt   = 1'b0;
      vs_nxt      = hlf_pkg::VS_IDLE;
      prev_cr_nxt = 1'b0;
      neg_nxt     = 1'b0;
      acc_nxt     = '0;
      rem_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= hlf_pkg::PH_HEADER;
      term_r    <= '0;
      kw_r      <= '0;
      found_r   <= 1'b0;
      vs_r      <= hlf_pkg::VS_IDLE;
      prev_cr_r <= 1'b0;
      neg_r     <= 1'b0;
      acc_r     <= '0;
      rem_r     <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      term_r    <= term_nxt;
      kw_r      <= kw_nxt;
      found_r   <= found_nxt;
      vs_r      <= vs_nxt;
      prev_cr_r <= prev_cr_nxt;
      neg_r     <= neg_nxt;
      acc_r     <= acc_nxt;
      rem_r     <= rem_nxt;
    end
  end

  // a body in progress always has bytes left to count
  a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == hlf_pkg::PH_BODY |-> rem_r != '0)
    else $error("body phase with zero remaining");

  // the value parser runs only after the keyword matched
  a_vs_found: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> vs_r == hlf_pkg::VS_IDLE)
    else $error("value state active without keyword");

  a_kw_full: assert property (@(posedge clk) disable iff (!rst_n)
    found_r == (kw_r == 4'(hlf_pkg::KW_LEN)))
    else $error("keyword count and found flag disagree");

  a_end_err: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(result.request_end && result.length_error))
    else $error("request end and length error on one byte");

endmodule

>>> rtl/hlf_out_stage.sv
`timescale 1ns / 1ps

module hlf_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  hlf_pkg::out_item_t result,
  output logic               load_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output hlf_pkg::out_item_t out_data
);

  logic               valid_r;
  logic               valid_nxt;
  hlf_pkg::out_item_t data_r;

  assign load_ok   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hlf_pkg::*;

  localparam logic [63:0] LEN_MAX      = (64'd1 << LEN_BITS_DEF) - 64'd1;
  localparam string       KEYWORD      = "content-length:";
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned STALL_CYCLES = 300;

  // Tracks the framing of the byte stream and holds the framed bytes still owed by the block.
  class frame_tracker;
    logic [1:0]  phase = PH_HEADER;
    int unsigned term_run;
    int unsigned kw_pos;
    bit          kw_seen;
    bit          prev_cr;
    bit          minus;
    logic [2:0]  val_st = VS_IDLE;
    logic [63:0] len_acc = '0;
    logic [63:0] remaining = '0;
    out_item_t   expected_bytes[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned ends;
    int unsigned errors;
    int unsigned body_bytes;
    int unsigned dropped;

    function void clear_parse();
      term_run  = 0;
      kw_pos    = 0;
      kw_seen   = 1'b0;
      val_st    = VS_IDLE;
      prev_cr   = 1'b0;
      minus     = 1'b0;
      len_acc   = '0;
      remaining = '0;
    endfunction

    function bit is_space_char(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function void value_step(logic [7:0] c);
      logic [63:0] d;
      bit digit;
      digit = c >= CH_ZERO && c <= CH_NINE;
      d = {56'd0, c} - {56'd0, CH_ZERO};
      if (c == CH_LF && prev_cr) begin
        val_st = (val_st == VS_DIGITS || val_st == VS_TRAIL) ? VS_VALID : VS_INVALID;
        return;
      end
      case (val_st)
        VS_LEAD: begin
          if (!is_space_char(c)) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
              minus  = (c == CH_MINUS);
              val_st = VS_SIGN;
            end else if (digit) begin
              len_acc = d;
              val_st  = VS_DIGITS;
            end else begin
              val_st = VS_INVALID;
            end
          end
        end
        VS_SIGN, VS_DIGITS: begin
          if (digit) begin
            // saturate to an error instead of wrapping
            if (len_acc > (LEN_MAX - d) / 10) begin
              val_st = VS_INVALID;
            end else begin
              len_acc = len_acc * 10 + d;
              val_st  = VS_DIGITS;
            end
          end else if (val_st == VS_DIGITS && is_space_char(c)) begin
            val_st = VS_TRAIL;
          end else begin
            val_st = VS_INVALID;
          end
        end
        VS_TRAIL: begin
          if (!is_space_char(c)) val_st = VS_INVALID;
        end
        default: ;
      endcase
    endfunction

    function void take_byte(in_item_t item);
      out_item_t   want;
      logic [7:0]  c;
      logic [7:0]  lower;
      bit          bad;
      c = item.data_byte;
      if (item.connection_start) begin
        phase = PH_HEADER;
        clear_parse();
      end
      want = '0;
      want.byte_out  = c;
      want.byte_part = PART_HEADER;
      if (phase == PH_BODY) begin
        want.byte_part = PART_BODY;
        remaining = (remaining - 64'd1) & LEN_MAX;
        if (remaining == 0) begin
          want.request_end = 1'b1;
          want.body_length = len_acc[31:0];
          phase = PH_HEADER;
          clear_parse();
        end
      end else if (phase != PH_HEADER) begin
        want.byte_part = PART_DROP;
      end else begin
        if (kw_seen && val_st >= VS_LEAD && val_st <= VS_TRAIL) value_step(c);
        if (!kw_seen) begin
          lower = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
          if (lower == KEYWORD[kw_pos]) kw_pos++;
          else kw_pos = (lower == CH_LO_C) ? 1 : 0;
          if (kw_pos >= KW_LEN) begin
            kw_seen = 1'b1;
            val_st  = VS_LEAD;
          end
        end
        if (c == CH_CR) begin
          term_run = (term_run == 2) ? 3 : 1;
        end else if (c == CH_LF && (term_run == 1 || term_run == 3)) begin
          term_run++;
        end else begin
          term_run = 0;
        end
        prev_cr = (c == CH_CR);
        if (term_run == 4) begin
          bad = val_st == VS_LEAD || val_st == VS_SIGN || val_st == VS_INVALID;
          if (minus && len_acc != 0) bad = 1'b1;
          if (val_st == VS_IDLE) len_acc = '0;
          if (bad) begin
            want.length_error = 1'b1;
            clear_parse();
            phase = PH_DROP;
          end else if (len_acc == 0) begin
            want.request_end = 1'b1;
            clear_parse();
          end else begin
            want.body_length = len_acc[31:0];
            remaining = len_acc;
            term_run  = 0;
            phase     = PH_BODY;
          end
        end
      end
      ends       += want.request_end;
      errors     += want.length_error;
      body_bytes += (want.byte_part == PART_BODY);
      dropped    += (want.byte_part == PART_DROP);
      expected_bytes.push_back(want);
    endfunction

    function void check_framed(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte: %02h part %0d end %0b err %0b len %0d",
                   got.byte_out, got.byte_part, got.request_end, got.length_error,
                   got.body_length);
      end else begin
        want = expected_bytes.pop_front();
        checked++;
        if (got.byte_out !== want.byte_out || got.byte_part !== want.byte_part ||
            got.request_end !== want.request_end || got.length_error !== want.length_error ||
            got.body_length !== want.body_length) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("byte %0d: expected %02h part %0d end %0b err %0b len %0d",
                     checked, want.byte_out, want.byte_part, want.request_end,
                     want.length_error, want.body_length);
            $display("  actual %02h part %0d end %0b err %0b len %0d",
                     got.byte_out, got.byte_part, got.request_end, got.length_error,
                     got.body_length);
          end
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  frame_tracker framer;
  logic [7:0]   tx_bytes[$];
  int unsigned  src_idle;
  int unsigned  sink_idle;
  int unsigned  bytes_sent;
  int unsigned  cycles;
  int unsigned  stall_reqs;
  int unsigned  stall_seen;
  int unsigned  stall_left;

  http_request_length_framer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycles,
               framer.expected_bytes.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_reqs != stall_seen) begin
      stall_seen = stall_reqs;
      stall_left = STALL_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) framer.check_framed(out_data);
  end

  task automatic send_byte(input logic [7:0] b, input bit start);
    in_item_t    item;
    int unsigned gap;
    item.data_byte        = b;
    item.connection_start = start;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    framer.take_byte(item);
    bytes_sent++;
  endtask

  task automatic flush(input int start_at);
    for (int i = 0; i < tx_bytes.size(); i++) send_byte(tx_bytes[i], i == start_at);
    tx_bytes.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endtask

  task automatic put_crlf();
    tx_bytes.push_back(CH_CR);
    tx_bytes.push_back(CH_LF);
  endtask

  task automatic put_blanks();
    repeat ($urandom_range(0, 2)) tx_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic put_keyword();
    logic [7:0] ch;
    for (int i = 0; i < KW_LEN; i++) begin
      ch = KEYWORD[i];
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - CASE_GAP;
      tx_bytes.push_back(ch);
    end
  endtask

  task automatic put_length_value();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      put_blanks();
      if ($urandom_range(0, 6) == 0) tx_bytes.push_back(CH_PLUS);
      if ($urandom_range(0, 9) == 0) put_text("00");
      if ($urandom_range(0, 9) == 0) put_text($sformatf("%0d", $urandom_range(25, 90)));
      else put_text($sformatf("%0d", $urandom_range(0, 24)));
      put_blanks();
    end else if (kind < 60) begin
      put_text($urandom_range(0, 1) ? "-0" : "-000");
    end else if (kind < 66) begin
      put_text($sformatf("-%0d", $urandom_range(1, 99)));
    end else if (kind < 72) begin
      case ($urandom_range(0, 3))
        0:       put_text("4294967296");
        1:       put_text("4294967300");
        2:       put_text("99999999999");
        default: put_text("18446744073709551616");
      endcase
    end else if (kind < 78) begin
      // blank between sign and digits or between digits
      if ($urandom_range(0, 3) == 0) begin
        tx_bytes.push_back(CH_PLUS);
        tx_bytes.push_back(CH_SPACE);
      end else begin
        put_text($sformatf("%0d", $urandom_range(1, 9)));
        case ($urandom_range(0, 3))
          0:       tx_bytes.push_back(CH_SPACE);
          1:       tx_bytes.push_back(CH_TAB);
          2:       tx_bytes.push_back(CH_LF);
          default: tx_bytes.push_back(CH_CR);
        endcase
      end
      put_text("7");
    end else if (kind < 84) begin
      put_blanks();
      case ($urandom_range(0, 2))
        0:       ;
        1:       tx_bytes.push_back(CH_PLUS);
        default: tx_bytes.push_back(CH_MINUS);
      endcase
    end else if (kind < 90) begin
      case ($urandom_range(0, 2))
        0:       put_text("12a");
        1:       put_text("0x10");
        default: put_text("abc");
      endcase
    end else if (kind < 95) begin
      put_text($urandom_range(0, 1) ? "4294967295" : "0004294967295");
    end else begin
      put_text($sformatf("%0d", $urandom_range(100, 3000)));
    end
  endtask

  task automatic put_filler();
    case ($urandom_range(0, 4))
      0:       put_text("Host: srv");
      1:       put_text("Content-Type: text/plain");
      2:       put_text("Accept: */*");
      3:       put_text("Content-Lengt: 8");
      default: put_text("Content-Length : 8");
    endcase
    put_crlf();
  endtask

  task automatic build_request();
    int unsigned cl_count;
    case ($urandom_range(0, 2))
      0:       put_text("GET /sum HTTP/1.1");
      1:       put_text("POST /calc HTTP/1.1");
      default: put_text("PUT /v HTTP/1.1");
    endcase
    put_crlf();
    repeat ($urandom_range(0, 2)) put_filler();
    cl_count = 1;
    if ($urandom_range(0, 6) == 0) cl_count = 0;
    else if ($urandom_range(0, 7) == 0) cl_count = 2;
    repeat (cl_count) begin
      // stutter the first letter so the match has to restart
      if ($urandom_range(0, 9) == 0) tx_bytes.push_back(CH_LO_C);
      put_keyword();
      put_length_value();
      put_crlf();
    end
    if ($urandom_range(0, 1)) put_filler();
    put_crlf();
  endtask

  task automatic one_request();
    int          start_at;
    int unsigned body_n;
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 8)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    build_request();
    start_at = (framer.phase != PH_HEADER || $urandom_range(0, 9) == 0) ? 0 : -1;
    // now and then cut the request with a new connection
    if ($urandom_range(0, 24) == 0) start_at = $urandom_range(1, tx_bytes.size() - 1);
    flush(start_at);
    if (framer.phase == PH_BODY) begin
      if (framer.remaining > 120 || $urandom_range(0, 19) == 0) body_n = $urandom_range(0, 20);
      else body_n = 32'(framer.remaining);
      repeat (body_n) tx_bytes.push_back(8'($urandom_range(0, 255)));
      flush(-1);
    end
  endtask

  task automatic run_traffic(input int unsigned count);
    int unsigned goal;
    goal = bytes_sent + count;
    while (bytes_sent < goal) one_request();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (framer.expected_bytes.size() != 0);
  endtask

  initial begin
    framer    = new;
    src_idle  = 22;
    sink_idle = 59;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // bare terminator: no length header, request ends on the terminator
    put_crlf();
    put_crlf();
    flush(0);
    put_text("content-length:-0");
    put_crlf();
    put_crlf();
    flush(-1);
    // too large, then bytes dropped until the next connection
    put_text("CONTENT-LENGTH: 4294967296");
    put_crlf();
    put_crlf();
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    flush(-1);
    // largest valid length, body abandoned by the next connection
    put_text("Content-Length:");
    tx_bytes.push_back(CH_TAB);
    put_text("4294967295 ");
    put_crlf();
    put_crlf();
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h00);
    flush(0);
    // only the first length header counts
    put_text("Content-length: 3");
    put_crlf();
    put_text("content-length: 9");
    put_crlf();
    put_crlf();
    put_text("abc");
    flush(0);
    put_text("content-length: 1 2");
    put_crlf();
    put_crlf();
    flush(-1);
    put_text("content-length: -7");
    put_crlf();
    put_crlf();
    flush(0);

    run_traffic(380);
    drain();
    src_idle  = 59;
    sink_idle = 22;
    run_traffic(380);
    drain();
    src_idle  = 0;
    sink_idle = 0;
    stall_reqs++;
    run_traffic(380);
    drain();
    repeat (10) @(posedge clk);

    $display("framed %0d bytes: %0d requests ended, %0d length errors, %0d body, %0d dropped",
             bytes_sent, framer.ends, framer.errors, framer.body_bytes, framer.dropped);
    $display("three idle mixes and one long output stall, %0d bytes checked, %0d mismatches",
             framer.checked, framer.mismatches);
    if (framer.mismatches == 0 && framer.expected_bytes.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
